// ----- hdl/tmds_pkg.sv -----
// Shared constants, item types and state codes for the trimmed-mean smoother.
// Depends on nothing; every other file of the block imports it.

package tmds_pkg;

	// Block and window lengths
	localparam int BLOCK_LEN = 10;
	localparam int WINDOW_LEN = 8;

	// Field widths
	localparam int SMP_W = 12;
	localparam int CNT_W = 16;
	localparam int SMP_MAX = (1 << SMP_W) - 1;

	// Samples kept after dropping the minimum and the maximum
	localparam int TRIM_DIV = BLOCK_LEN - 2;

	// Derived widths of counters and sums
	localparam int POS_W = $clog2(BLOCK_LEN);
	localparam int SUM_W = $clog2(BLOCK_LEN * SMP_MAX + 1);
	localparam int WSUM_W = $clog2(WINDOW_LEN * SMP_MAX + 1);
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	// Trimmed mean by reciprocal multiplication, exact for any SUM_W-bit rest
	localparam int TRIM_SH = SUM_W + $clog2(TRIM_DIV);
	localparam int MUL_W = SUM_W + 1;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam longint TRIM_MUL_L =
		((longint'(1) << TRIM_SH) + longint'(TRIM_DIV) - 1) / longint'(TRIM_DIV);
	localparam logic [MUL_W-1:0] TRIM_MUL = MUL_W'(TRIM_MUL_L);

	// Serial divider sizing: dividend is a window sum, divisor a fill count
	localparam int DVD_W = WSUM_W;
	localparam int DVS_W = $clog2(WINDOW_LEN + 1);
	localparam int STEP_W = $clog2(DVD_W + 1);

	// One input item: a conversion pair
	typedef struct packed {
		logic [SMP_W-1:0] sample_ch1;
		logic [SMP_W-1:0] sample_ch2;
	} sample_t;

	// One result item
	typedef struct packed {
		logic [SMP_W-1:0] smoothed_ch1;
		logic [SMP_W-1:0] smoothed_ch2;
		logic [CNT_W-1:0] block_number;
	} result_t;

	// Finished block of one channel lane
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
		logic [SMP_W-1:0] min;
		logic [SMP_W-1:0] max;
	} lane_result_t;

	// Merge stage sequencer
	typedef enum logic [2:0] {
		MRG_IDLE,
		MRG_TRIM,
		MRG_WIN,
		MRG_AVG,
		MRG_OUT
	} merge_state_t;

endpackage

// ----- hdl/trimmed_mean_decimating_smoother.sv -----
// Top level of the two-channel trimmed-mean decimating smoother.
// Depends on tmds_pkg, tmds_lane and tmds_merge.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------
//  sample   | sample_valid / sample_stall   | sample_t: conversion pair
//  result   | result_valid / result_stall   | result_t: both averages, count
//
// Samples are taken one per cycle. The item that closes a block is held off
// while the previous block is still being reduced or its result waits.
// A result is offered after its block's closing item is taken and has passed
// through hand-over, trimming, window update and the bit-serial divider for
// the running average, followed by a load of that average into the result.
// The next closing item can be taken the cycle after the result is taken.
// Reset clears all counters and sums; the window store needs no clearing pass.
// A stalled result holds the merge stage but not the block accumulation.

module trimmed_mean_decimating_smoother import tmds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic [POS_W-1:0] pos_q;
	logic             last;
	logic             take;
	logic             merge_busy;
	lane_result_t     fin1, fin2;

	// Hold off the block's closing item while the merge stage is occupied
	always_comb begin
		last = pos_q == POS_W'(BLOCK_LEN - 1);
		sample_stall = last && (merge_busy || fin1.valid);
		take = sample_valid && !sample_stall;
	end

	// Advance the position within the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= last ? '0 : pos_q + 1'b1;
		end
	end

	tmds_lane u_lane1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.last      (last),
		.sample_in (sample.sample_ch1),
		.fin       (fin1)
	);

	tmds_lane u_lane2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.last      (last),
		.sample_in (sample.sample_ch2),
		.fin       (fin2)
	);

	tmds_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.fin1         (fin1),
		.fin2         (fin2),
		.busy         (merge_busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- hdl/tmds_lane.sv -----
// One channel lane: block sum, minimum and maximum over BLOCK_LEN samples.
// Depends on tmds_pkg.

module tmds_lane import tmds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic             last,
	input  logic [SMP_W-1:0] sample_in,
	output lane_result_t     fin
);

	logic [SUM_W-1:0] sum_q, sum_d;
	logic [SMP_W-1:0] min_q, min_d;
	logic [SMP_W-1:0] max_q, max_d;
	logic             done_q;
	logic [SUM_W-1:0] fin_sum_q;
	logic [SMP_W-1:0] fin_min_q;
	logic [SMP_W-1:0] fin_max_q;

	// Fold the new sample into the running block figures
	always_comb begin
		sum_d = sum_q + SUM_W'(sample_in);
		min_d = (sample_in < min_q) ? sample_in : min_q;
		max_d = (sample_in > max_q) ? sample_in : max_q;
	end

	// Advance the block; at its end hand the totals over and start afresh
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= take && last;
			if (take) begin
				if (last) begin
					sum_q <= '0;
					min_q <= '1;
					max_q <= '0;
				end else begin
					sum_q <= sum_d;
					min_q <= min_d;
					max_q <= max_d;
				end
			end
		end
	end

	// Hold the finished block for the merge stage
	always_ff @(posedge clk) begin
		if (take && last) begin
			fin_sum_q <= sum_d;
			fin_min_q <= min_d;
			fin_max_q <= max_d;
		end
	end

	assign fin.valid = done_q;
	assign fin.sum = fin_sum_q;
	assign fin.min = fin_min_q;
	assign fin.max = fin_max_q;

endmodule

// ----- hdl/tmds_divider.sv -----
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on tmds_pkg for the dividend and divisor widths.

module tmds_divider import tmds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVS_W-1:0]  div_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		fits = trial >= {1'b0, div_q};
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, div_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/tmds_merge.sv -----
// Merge stage: trimmed means of both lanes, window store and running averages.
// Depends on tmds_pkg and tmds_divider.

module tmds_merge import tmds_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lane_result_t fin1,
	input  lane_result_t fin2,
	output logic         busy,
	output logic         result_valid,
	input  logic         result_stall,
	output result_t      result
);

	merge_state_t state_q, state_d;

	logic              take_mean;
	logic              do_win;
	logic              load_out;
	logic              div_start;
	logic [DVD_W-1:0]  dvd1, dvd2;
	logic [DVS_W-1:0]  dvs;
	logic              done1, done2;
	logic [DVD_W-1:0]  quo1, quo2;
	logic [SUM_W-1:0]  rest1, rest2;
	logic [PROD_W-1:0] prod1, prod2;

	logic [IDX_W-1:0]  idx_q;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              warm;
	logic [WSUM_W-1:0] wsum1_q, wsum2_q, wsum1_d, wsum2_d;
	logic [WSUM_W:0]   wacc1, wacc2;
	logic [SMP_W-1:0]  mean1_q, mean2_q;
	logic [SMP_W-1:0]  old1, old2;
	logic [CNT_W-1:0]  count_q;
	result_t           result_q;

	logic [2*SMP_W-1:0] win_mem [WINDOW_LEN];
	logic [2*SMP_W-1:0] rd_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			MRG_IDLE: if (fin1.valid) state_d = MRG_TRIM;
			MRG_TRIM: state_d = MRG_WIN;
			MRG_WIN:  state_d = MRG_AVG;
			MRG_AVG:  if (done1 && done2) state_d = MRG_OUT;
			MRG_OUT:  if (!result_stall) state_d = MRG_IDLE;
			default:  state_d = MRG_IDLE;
		endcase
	end

	// Step strobes
	always_comb begin
		take_mean = 1'b0;
		do_win = 1'b0;
		load_out = 1'b0;
		case (state_q)
			MRG_IDLE: ;
			MRG_TRIM: take_mean = 1'b1;
			MRG_WIN:  do_win = 1'b1;
			MRG_AVG:  load_out = done1 && done2;
			MRG_OUT:  ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MRG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Drop the block extremes from the sums and scale by the reciprocal
	always_comb begin
		rest1 = fin1.sum - SUM_W'(fin1.min) - SUM_W'(fin1.max);
		rest2 = fin2.sum - SUM_W'(fin2.min) - SUM_W'(fin2.max);
		prod1 = PROD_W'(rest1) * PROD_W'(TRIM_MUL);
		prod2 = PROD_W'(rest2) * PROD_W'(TRIM_MUL);
	end

	// Replace the oldest window entry; entries never written count as zero
	always_comb begin
		warm = fill_q < FILL_W'(WINDOW_LEN);
		fill_d = warm ? fill_q + 1'b1 : fill_q;
		old1 = warm ? '0 : rd_q[SMP_W-1:0];
		old2 = warm ? '0 : rd_q[2*SMP_W-1:SMP_W];
		wacc1 = {1'b0, wsum1_q} + (WSUM_W+1)'(mean1_q) - (WSUM_W+1)'(old1);
		wacc2 = {1'b0, wsum2_q} + (WSUM_W+1)'(mean2_q) - (WSUM_W+1)'(old2);
		wsum1_d = wacc1[WSUM_W-1:0];
		wsum2_d = wacc2[WSUM_W-1:0];
	end

	// Divider operands: window sums over the filled entry count
	always_comb begin
		div_start = do_win;
		dvd1 = DVD_W'(wsum1_d);
		dvd2 = DVD_W'(wsum2_d);
		dvs = DVS_W'(fill_d);
	end

	tmds_divider u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd1),
		.divisor  (dvs),
		.done     (done1),
		.quotient (quo1)
	);

	tmds_divider u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd2),
		.divisor  (dvs),
		.done     (done2),
		.quotient (quo2)
	);

	// Window store: write the new means, read the entry due for replacement
	always_ff @(posedge clk) begin
		if (do_win) begin
			win_mem[idx_q] <= {mean2_q, mean1_q};
		end
		rd_q <= win_mem[idx_q];
	end

	// Window bookkeeping and result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum1_q <= '0;
			wsum2_q <= '0;
			fill_q <= '0;
			idx_q <= '0;
			count_q <= '0;
		end else begin
			if (do_win) begin
				wsum1_q <= wsum1_d;
				wsum2_q <= wsum2_d;
				fill_q <= fill_d;
			end
			if (load_out) begin
				count_q <= count_q + 1'b1;
				if (idx_q == IDX_W'(WINDOW_LEN - 1)) begin
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// Capture the means and the finished item
	always_ff @(posedge clk) begin
		if (take_mean) begin
			mean1_q <= SMP_W'(prod1 >> TRIM_SH);
			mean2_q <= SMP_W'(prod2 >> TRIM_SH);
		end
		if (load_out) begin
			result_q.smoothed_ch1 <= quo1[SMP_W-1:0];
			result_q.smoothed_ch2 <= quo2[SMP_W-1:0];
			result_q.block_number <= count_q + 1'b1;
		end
	end

	assign busy = state_q != MRG_IDLE;
	assign result_valid = state_q == MRG_OUT;
	assign result = result_q;

endmodule

// ----- hdl/tmds_checker.sv -----
// Port-level checks for the trimmed-mean smoother, bound to the top level.
// Depends on tmds_pkg.

module tmds_checker import tmds_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_valid,
	input logic    sample_stall,
	input sample_t sample,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled result stays offered and unchanged
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result item dropped or changed");

	// Taken results are never followed at once by another
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall |=> !result_valid)
		else $error("result item offered straight after a taken one");

	// No result leaves reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result item offered on leaving reset");

	// A held sample stays held while the previous result is still stalled
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall && result_valid && result_stall |=> sample_stall)
		else $error("sample intake released while a result item waits");

endmodule

bind trimmed_mean_decimating_smoother tmds_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.sample       (sample),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
